>>> rtl/core/olh_pkg.sv
// Shared constants, opcodes and cell control type for the ordered handle list.
package olh_pkg;

   localparam int CAPACITY    = 16;
   localparam int HANDLE_BITS = 32;

   localparam int OP_W     = 2;
   localparam int POS_W    = 5;
   localparam int HANDLE_W = 32;
   localparam int COUNT_W  = 5;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

   typedef struct packed {
      logic                   update;
      logic                   shift_up;
      logic [CMP_W-1:0]       pos;
      logic [HANDLE_BITS-1:0] handle;
   } ctrl_type;

endpackage

>>> rtl/core/olh_cell.sv
// One list slot that shifts up or down with its neighbors and joins the read chain.
module olh_cell (
   input  logic                           clock,
   input  olh_pkg::ctrl_type              ctrl,
   input  logic [olh_pkg::CMP_W-1:0]      cell_idx,
   input  logic [olh_pkg::HANDLE_BITS-1:0] lower_slot,
   input  logic [olh_pkg::HANDLE_BITS-1:0] upper_slot,
   input  logic [olh_pkg::HANDLE_BITS-1:0] read_in,
   output logic [olh_pkg::HANDLE_BITS-1:0] slot,
   output logic [olh_pkg::HANDLE_BITS-1:0] read_out
);

   logic [olh_pkg::HANDLE_BITS-1:0] slot_ff;
   logic [olh_pkg::HANDLE_BITS-1:0] slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.update) begin
         if (ctrl.shift_up) begin
            if (cell_idx > ctrl.pos) begin
               slot_in = lower_slot;
            end else if (cell_idx == ctrl.pos) begin
               slot_in = ctrl.handle;
            end
         end else begin
            if (cell_idx >= ctrl.pos) begin
               slot_in = upper_slot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot     = slot_ff;
   assign read_out = read_in | ((cell_idx == ctrl.pos) ? slot_ff : '0);

endmodule

>>> rtl/core/ordered_handle_list_top.sv
// Top level of the ordered handle list: request decode, count and response register.
// The list holds up to sixteen handles in a row of cells. Every cell sees the
// decoded request, so an insert shifts all later entries up and a remove shifts
// them down in the same cycle; the response to each request is registered, so a
// new request is taken in every cycle that the response side keeps up. Reads
// select the entry through an OR chain along the cells. An append or insert on
// a full list, or a position outside the valid range, returns ok low, handle
// zero and the unchanged count.
module ordered_handle_list_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_position,
   input  logic [31:0] req_handle_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [31:0] rsp_handle_out,
   output logic [4:0]  rsp_count
);

   localparam int CAP = olh_pkg::CAPACITY;
   localparam int HB  = olh_pkg::HANDLE_BITS;
   localparam int CW  = olh_pkg::CMP_W;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic [31:0]              rsp_handle_ff, rsp_handle_in;
   logic [4:0]               rsp_count_ff, rsp_count_in;
   logic [CW-1:0]            count_ff, count_in;

   logic                     accept;
   logic [CW-1:0]            pos_ext;
   logic                     ok;
   olh_pkg::ctrl_type        ctrl;

   logic [HB-1:0] slots [CAP];
   logic [HB-1:0] chain [CAP+1];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pos_ext   = CW'(req_position);

   always_comb begin
      ok            = 1'b0;
      ctrl.shift_up = 1'b1;
      ctrl.pos      = pos_ext;
      ctrl.handle   = HB'(req_handle_in);
      unique case (req_opcode)
         olh_pkg::OP_APPEND: begin
            ok       = count_ff < CW'(CAP);
            ctrl.pos = count_ff;
         end
         olh_pkg::OP_INSERT: begin
            ok = (count_ff < CW'(CAP)) && (pos_ext <= count_ff);
         end
         olh_pkg::OP_READ: begin
            ok = pos_ext < count_ff;
         end
         olh_pkg::OP_REMOVE: begin
            ok            = pos_ext < count_ff;
            ctrl.shift_up = 1'b0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      ctrl.update = accept && ok && (req_opcode != olh_pkg::OP_READ);
   end

   assign chain[0] = '0;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [HB-1:0] lower;
      logic [HB-1:0] upper;
      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_mid
         assign lower = slots[i-1];
      end
      if (i == CAP - 1) begin : g_last
         assign upper = slots[i];
      end else begin : g_inner
         assign upper = slots[i+1];
      end
      olh_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_idx   (CW'(i)),
         .lower_slot (lower),
         .upper_slot (upper),
         .read_in    (chain[i]),
         .slot       (slots[i]),
         .read_out   (chain[i+1])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = ok;
         rsp_handle_in = '0;
         if (ok) begin
            if (ctrl.update) begin
               count_in = ctrl.shift_up ? count_ff + 1'b1 : count_ff - 1'b1;
            end
            if (req_opcode == olh_pkg::OP_READ || req_opcode == olh_pkg::OP_REMOVE) begin
               rsp_handle_in = 32'(chain[CAP]);
            end
         end
         rsp_count_in = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff     <= rsp_ok_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_count      = rsp_count_ff;

endmodule
